// ----- hdl/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg - shared types and constants
// Ring geometry, command kinds and the transaction structs of the byte ring fifo.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  // ring geometry, power of two, 4 .. 65536
  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);

  // fixed field widths of the transactions
  localparam int CNT_W  = 10;
  localparam int BYTE_W = 8;
  localparam int DROP_W = 32;

  // width that holds both an index-sized count and a field-sized count
  localparam int SUM_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  // largest fill level: one slot always stays free
  localparam logic [IDX_W-1:0] FILL_MAX = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_SKIP  = 2'd2,
    KIND_EMPTY = 2'd3
  } brf_kind_t;

  typedef struct packed {
    brf_kind_t         kind;
    logic [BYTE_W-1:0] wr_byte;
    logic [CNT_W-1:0]  skip_count;
  } brf_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_valid;
    logic              wr_accepted;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  high_water;
    logic [DROP_W-1:0] dropped_total;
  } brf_res_t;

  // statistics update for one write
  typedef struct packed {
    logic             wr_evt;
    logic             drop;
    logic [IDX_W-1:0] used_after;
  } brf_stat_upd_t;

endpackage

`default_nettype wire

// ----- hdl/brf_ram.sv -----
// ----------------------------------------------------------------------------
// brf_ram - simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/brf_stats.sv -----
// ----------------------------------------------------------------------------
// brf_stats - fill statistics
// Keeps the high-water mark of the fill level and the wrapping drop counter.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_stats
  import brf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire brf_stat_upd_t     upd,
  output logic      [IDX_W-1:0]  peak,
  output logic      [DROP_W-1:0] dropped
);

  logic [IDX_W-1:0]  peak_next;
  logic [DROP_W-1:0] dropped_next;

  always_comb begin
    peak_next    = peak;
    dropped_next = dropped;
    if (upd.wr_evt) begin
      if (upd.used_after > peak) begin
        peak_next = upd.used_after;
      end
      if (upd.drop) begin
        dropped_next = dropped + DROP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak    <= '0;
      dropped <= '0;
    end else begin
      peak    <= peak_next;
      dropped <= dropped_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/byte_ring_fifo_with_drop_stats_core.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_drop_stats_core - byte fifo with drop statistics
// Ring buffer of bytes in a synchronous ram, with high-water mark and drop count.
// ----------------------------------------------------------------------------
// usage
//   command channel: a transaction is taken at a rising edge with start high
//   and busy low; cmd carries the kind (write, read, skip, empty ring), the
//   byte to write and the skip count
//   result channel: strobe is high for exactly one cycle, in the cycle after
//   the command was taken; result is valid only in that cycle
//   the ram read issued when a read is taken lands in its output register
//   at the edge that takes the read
//   throughput: 1 transaction per cycle; busy is high only during reset, since
//   the ram write of one command is committed before the read of the next
//   command is issued
//   the ring holds at most DEPTH-1 bytes; a write on a full ring is dropped
//   and counted; a skip is clamped to the bytes stored
//   reset: indices, high-water mark and drop count clear; ram contents are
//   left as they are and are never read before being written
//   the receiver cannot stall: a result not taken in its strobe cycle is lost
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_drop_stats_core
  import brf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire brf_cmd_t cmd,
  output logic          strobe,
  output brf_res_t      result
);

  // ring indices
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx_next;
  logic [IDX_W-1:0] rd_idx_next;
  logic [IDX_W-1:0] used;

  // per-transaction flags held for the result cycle
  logic res_rd_valid;
  logic res_wr_accepted;
  logic rd_valid_next;
  logic wr_accepted_next;

  logic take;

  // ram ports
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_q;

  // clamp arithmetic for skip
  logic [SUM_W-1:0] skip_ext;
  logic [SUM_W-1:0] used_ext;
  logic [SUM_W-1:0] skip_amt;

  brf_stat_upd_t     stat_upd;
  logic [IDX_W-1:0]  peak;
  logic [DROP_W-1:0] dropped;

  // one command per cycle, nothing taken while in reset
  assign busy = rst;
  assign take = start && !busy;

  // fill level wraps naturally on the index width
  assign used = wr_idx - rd_idx;

  assign skip_ext = SUM_W'(cmd.skip_count);
  assign used_ext = SUM_W'(used);
  assign skip_amt = (skip_ext > used_ext) ? used_ext : skip_ext;

  // command decode
  always_comb begin
    wr_idx_next      = wr_idx;
    rd_idx_next      = rd_idx;
    rd_valid_next    = 1'b0;
    wr_accepted_next = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    stat_upd         = '0;
    if (take) begin
      unique case (cmd.kind)
        KIND_WRITE: begin
          stat_upd.wr_evt = 1'b1;
          if (used != FILL_MAX) begin
            ram_we              = 1'b1;
            wr_idx_next         = wr_idx + IDX_W'(1);
            wr_accepted_next    = 1'b1;
            stat_upd.used_after = used + IDX_W'(1);
          end else begin
            stat_upd.drop       = 1'b1;
            stat_upd.used_after = used;
          end
        end
        KIND_READ: begin
          if (used != '0) begin
            ram_re        = 1'b1;
            rd_valid_next = 1'b1;
            rd_idx_next   = rd_idx + IDX_W'(1);
          end
        end
        KIND_SKIP: begin
          rd_idx_next = rd_idx + skip_amt[IDX_W-1:0];
        end
        KIND_EMPTY: begin
          wr_idx_next = '0;
          rd_idx_next = '0;
        end
        default: begin
          wr_idx_next = wr_idx;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx          <= '0;
      rd_idx          <= '0;
      strobe          <= 1'b0;
      res_rd_valid    <= 1'b0;
      res_wr_accepted <= 1'b0;
    end else begin
      wr_idx          <= wr_idx_next;
      rd_idx          <= rd_idx_next;
      strobe          <= take;
      res_rd_valid    <= rd_valid_next;
      res_wr_accepted <= wr_accepted_next;
    end
  end

  brf_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (cmd.wr_byte),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  brf_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .upd     (stat_upd),
    .peak    (peak),
    .dropped (dropped)
  );

  // result: indices, statistics and ram data all settled at the edge that
  // took the command, so the result cycle reads them directly
  always_comb begin
    result.rd_byte       = res_rd_valid ? ram_q : '0;
    result.rd_valid      = res_rd_valid;
    result.wr_accepted   = res_wr_accepted;
    result.used_count    = CNT_W'(used);
    result.free_count    = CNT_W'(FILL_MAX - used);
    result.high_water    = CNT_W'(peak);
    result.dropped_total = dropped;
  end

endmodule

`default_nettype wire

// ----- hdl/brf_checker.sv -----
// ----------------------------------------------------------------------------
// brf_checker - port-level checks
// Watches the command and result ports of the byte ring fifo core.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_checker
  import brf_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire brf_cmd_t cmd,
  input wire logic     strobe,
  input wire brf_res_t result
);

  localparam logic [CNT_W-1:0] FREE_SUM = CNT_W'(DEPTH - 1);

  // each taken transaction gives exactly one result, in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> strobe)
    else $error("missing result after command");

  assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !strobe)
    else $error("result without command");

  // used and free always add up to the ring capacity
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> (CNT_W'(result.used_count + result.free_count) == FREE_SUM))
    else $error("used and free counts disagree");

  // after a write the high-water mark covers the fill level and no read is flagged
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.kind == KIND_WRITE) |=>
      (result.high_water >= result.used_count && !result.rd_valid))
    else $error("high-water mark below fill level after write");

  // a read result carries no write flag, and a result without a read has a zero byte
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> (!(result.rd_valid && result.wr_accepted)
                && (result.rd_valid || result.rd_byte == '0)))
    else $error("inconsistent result flags");

endmodule

bind byte_ring_fifo_with_drop_stats_core brf_checker u_brf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .strobe (strobe),
  .result (result)
);

`default_nettype wire

// ----- sim/byte_ring_fifo_with_drop_stats_core_tb.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_drop_stats_core_tb - self-checking bench for the byte ring fifo
// Drives write, read, skip and empty-ring commands, predicts each status word
// with a shadow ring in a scoreboard and compares every strobed result.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_drop_stats_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int MAX_SHOWN      = 10;    // mismatches printed in full
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int TAIL_CYCLES    = 8;     // settle time after the last result
  localparam int PHASE_ITEMS    = 35;    // random commands per idling phase

  // --------------------------------------------------------------------------
  // scoreboard: shadow ring, statistics and the queue of status words due
  // --------------------------------------------------------------------------
  class fifo_status_board;
    logic [BYTE_W-1:0] shadow_ring [DEPTH];
    logic [IDX_W-1:0]  wr_ptr;
    logic [IDX_W-1:0]  rd_ptr;
    logic [IDX_W-1:0]  peak_fill;
    logic [DROP_W-1:0] drop_cnt;
    brf_res_t          status_due [$];
    int                mismatches;
    int                checked;
    int                kind_hits [4];

    function new();
      wr_ptr     = '0;
      rd_ptr     = '0;
      peak_fill  = '0;
      drop_cnt   = '0;
      mismatches = 0;
      checked    = 0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
    endfunction

    function string fmt_status(brf_res_t s);
      return $sformatf("byte %h valid %b acc %b used %0d free %0d hw %0d drops %0d",
                       s.rd_byte, s.rd_valid, s.wr_accepted, s.used_count,
                       s.free_count, s.high_water, s.dropped_total);
    endfunction

    // accepted command: advance the shadow ring and queue the status it causes
    function void take_command(brf_cmd_t c);
      brf_res_t    r;
      logic [IDX_W-1:0] fill;
      int unsigned n;
      r    = '0;
      fill = wr_ptr - rd_ptr;
      kind_hits[int'(c.kind)]++;
      case (c.kind)
        KIND_WRITE: begin
          if (fill < FILL_MAX) begin
            shadow_ring[wr_ptr] = c.wr_byte;
            wr_ptr = wr_ptr + IDX_W'(1);
            r.wr_accepted = 1'b1;
          end else begin
            drop_cnt = drop_cnt + DROP_W'(1);
          end
          // high-water mark is looked at after every write, dropped or not
          fill = wr_ptr - rd_ptr;
          if (fill > peak_fill) peak_fill = fill;
        end
        KIND_READ: begin
          if (fill != '0) begin
            r.rd_byte  = shadow_ring[rd_ptr];
            r.rd_valid = 1'b1;
            rd_ptr = rd_ptr + IDX_W'(1);
          end
        end
        KIND_SKIP: begin
          n = c.skip_count;
          if (n > fill) n = fill;
          rd_ptr = rd_ptr + IDX_W'(n);
        end
        KIND_EMPTY: begin
          wr_ptr = '0;
          rd_ptr = '0;
        end
      endcase
      fill = wr_ptr - rd_ptr;
      r.used_count    = CNT_W'(fill);
      r.free_count    = CNT_W'(FILL_MAX - fill);
      r.high_water    = CNT_W'(peak_fill);
      r.dropped_total = drop_cnt;
      status_due.push_back(r);
    endfunction

    // strobed result: compare with the oldest status due
    function void check_status(brf_res_t got);
      brf_res_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result with no command outstanding: %s", fmt_status(got));
        return;
      end
      want = status_due.pop_front();
      checked++;
      if (got.rd_byte       !== want.rd_byte    || got.rd_valid   !== want.rd_valid   ||
          got.wr_accepted   !== want.wr_accepted || got.used_count !== want.used_count ||
          got.free_count    !== want.free_count || got.high_water !== want.high_water ||
          got.dropped_total !== want.dropped_total) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("status mismatch %0d at %0t", mismatches, $realtime);
          $display("  expected %s", fmt_status(want));
          $display("  actual   %s", fmt_status(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, dut and bench state
  // --------------------------------------------------------------------------
  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  brf_cmd_t cmd;
  logic     strobe;
  brf_res_t result;

  fifo_status_board board;
  int idle_pct;     // chance per cycle that the sender holds back
  int quiet_left;   // commands left in a stretch with no sender gaps
  int idle_edges;   // watchdog count

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  byte_ring_fifo_with_drop_stats_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  // --------------------------------------------------------------------------
  // monitor: everything sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) board.check_status(result);
      if (start && !busy) board.take_command(cmd);
    end
  end

  // watchdog: cycles in which neither a command nor a result moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_edges <= 0;
    end else begin
      idle_edges <= idle_edges + 1;
      if (idle_edges >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("byte_ring_fifo_with_drop_stats_core_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic brf_cmd_t cmd_of(brf_kind_t k, logic [BYTE_W-1:0] b,
                                      logic [CNT_W-1:0] s);
    brf_cmd_t c;
    c.kind       = k;
    c.wr_byte    = b;
    c.skip_count = s;
    return c;
  endfunction

  // fully random command, unused fields included
  function automatic brf_cmd_t junk_cmd();
    return cmd_of(brf_kind_t'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                  CNT_W'($urandom_range(1023)));
  endfunction

  // single command with a mix that keeps the ring partly filled
  function automatic brf_cmd_t mixed_cmd();
    brf_cmd_t c;
    int roll;
    c    = junk_cmd();
    roll = $urandom_range(99);
    if (roll < 45)      c.kind = KIND_WRITE;
    else if (roll < 82) c.kind = KIND_READ;
    else if (roll < 94) begin
      c.kind = KIND_SKIP;
      // half the time short skips, else anything up to the field maximum
      if ($urandom_range(1)) c.skip_count = CNT_W'($urandom_range(4));
    end else begin
      c.kind = KIND_EMPTY;
    end
    return c;
  endfunction

  // one command transaction, with random sender gaps before it
  task automatic issue(brf_cmd_t c);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(99) < 3) begin
      quiet_left = $urandom_range(40, 10);
    end
    if (quiet_left == 0) begin
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
        start <= 1'b0;
        cmd   <= junk_cmd();
      end
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // hold the sender until every status word due has arrived
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (board.status_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_burst(int len);
    repeat (len)
      issue(cmd_of(KIND_WRITE, BYTE_W'($urandom_range(255)), CNT_W'($urandom_range(1023))));
  endtask

  task automatic run_phase(int pct, int items, bit flood);
    int done;
    int roll;
    int len;
    idle_pct   = pct;
    quiet_left = 0;
    done       = 0;
    // flood: fill the ring to the brim and write into the drop path
    if (flood) begin
      issue(cmd_of(KIND_EMPTY, '0, '0));
      write_burst(DEPTH + 1);
      issue(cmd_of(KIND_SKIP, 8'hFF, CNT_W'(DEPTH / 2)));
    end
    while (done < items) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        len = $urandom_range(200, 20);
        if (len > items - done) len = items - done;
        write_burst(len);
      end else if (roll < 6) begin
        len = $urandom_range(120, 10);
        if (len > items - done) len = items - done;
        repeat (len) begin
          issue(cmd_of(KIND_READ, BYTE_W'($urandom_range(255)),
                       CNT_W'($urandom_range(1023))));
        end
      end else begin
        len = 1;
        issue(mixed_cmd());
      end
      done += len;
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    board      = new();
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    idle_pct   = 0;
    quiet_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-ring corner cases first
    issue(cmd_of(KIND_READ,  8'hFF, 10'h3FF));   // read on an empty ring
    issue(cmd_of(KIND_SKIP,  8'h00, 10'h3FF));   // skip clamped to nothing
    issue(cmd_of(KIND_EMPTY, 8'hFF, 10'h3FF));   // empty an empty ring
    // byte extremes through the ring
    issue(cmd_of(KIND_WRITE, 8'h00, 10'h3FF));
    issue(cmd_of(KIND_WRITE, 8'hFF, 10'h000));
    issue(cmd_of(KIND_WRITE, 8'hA5, 10'h155));
    issue(cmd_of(KIND_WRITE, 8'h5A, 10'h2AA));
    issue(cmd_of(KIND_READ,  8'h00, 10'h000));   // returns 00
    issue(cmd_of(KIND_SKIP,  8'hFF, 10'h000));   // zero skip
    issue(cmd_of(KIND_SKIP,  8'h00, 10'h001));   // discards ff
    issue(cmd_of(KIND_READ,  8'hFF, 10'h3FF));   // returns a5
    issue(cmd_of(KIND_WRITE, 8'h3C, 10'h3FF));
    issue(cmd_of(KIND_SKIP,  8'hFF, 10'h3FF));   // skip longer than stored
    issue(cmd_of(KIND_READ,  8'h00, 10'h000));   // empty again
    issue(cmd_of(KIND_WRITE, 8'h81, 10'h000));
    issue(cmd_of(KIND_WRITE, 8'h7E, 10'h000));
    issue(cmd_of(KIND_EMPTY, 8'h00, 10'h000));   // indices back to zero, stats kept
    issue(cmd_of(KIND_READ,  8'hFF, 10'h3FF));
    issue(cmd_of(KIND_WRITE, 8'h55, 10'h200));
    issue(cmd_of(KIND_READ,  8'hAA, 10'h1FF));   // returns 55
    drain_results();

    // random phases: no gaps, heavy gaps, no gaps, moderate gaps with the flood
    run_phase(0,  PHASE_ITEMS, 1'b0);
    run_phase(82, PHASE_ITEMS, 1'b0);
    run_phase(0,  PHASE_ITEMS, 1'b0);
    run_phase(34, PHASE_ITEMS, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d writes, %0d reads, %0d skips, %0d ring empties; %0d results checked",
             board.kind_hits[int'(KIND_WRITE)], board.kind_hits[int'(KIND_READ)],
             board.kind_hits[int'(KIND_SKIP)], board.kind_hits[int'(KIND_EMPTY)],
             board.checked);
    $display("ring reached fill %0d with %0d writes dropped; %0d mismatches, %0d missing",
             board.peak_fill, board.drop_cnt, board.mismatches, board.status_due.size());
    if (board.mismatches == 0 && board.status_due.size() == 0) begin
      $display("byte_ring_fifo_with_drop_stats_core_tb: PASS");
    end else begin
      $display("byte_ring_fifo_with_drop_stats_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
